/* rtl/pxu_pkg.sv */
// ============================================================================
// pxu_pkg - pixel unpacker shared definitions
// Widths, register indexes, format codes, colour expansion tables and the
// structs passed between the unpacker modules.
// ============================================================================
`default_nettype none

package pxu_pkg;

    // Address and register widths
    localparam int ADDR_BITS      = 24;
    localparam int MAX_WIDTH      = 4096;
    localparam int WIDTH_BITS     = 13;
    localparam int PITCH_BITS     = 15;
    localparam int BUDGET_BITS    = 27;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 27;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

    // Pixel formats
    typedef enum logic [1:0] {
        FMT_RGBA   = 2'd0,
        FMT_RGB    = 2'd1,
        FMT_RGB565 = 2'd2,
        FMT_RGBXOR = 2'd3
    } t_format;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_FORMAT       = 3'd0,
        REG_ROW_WIDTH    = 3'd1,
        REG_ROW_PITCH    = 3'd2,
        REG_START_OFFSET = 3'd3,
        REG_FRAME_BYTES  = 3'd4
    } t_cfg_reg;

    typedef struct packed {
        t_format                format;
        logic [WIDTH_BITS-1:0]  row_width;
        logic [PITCH_BITS-1:0]  row_pitch;
        logic [ADDR_BITS-1:0]   start_offset;
        logic [BUDGET_BITS-1:0] frame_bytes;
    } t_cfg;

    typedef struct packed {
        logic                 pixel_valid;
        logic [ADDR_BITS-1:0] pixel_address;
        logic [31:0]          pixel_value;
        logic                 xor_merge;
        logic                 frame_done;
        logic                 overrun;
    } t_result;

    // 5-bit and 6-bit channel expansion with rounding
    localparam logic [7:0] EXPAND5 [32] = '{
        8'd0,   8'd8,   8'd16,  8'd25,  8'd33,  8'd41,  8'd49,  8'd58,
        8'd66,  8'd74,  8'd82,  8'd90,  8'd99,  8'd107, 8'd115, 8'd123,
        8'd132, 8'd140, 8'd148, 8'd156, 8'd165, 8'd173, 8'd181, 8'd189,
        8'd197, 8'd206, 8'd214, 8'd222, 8'd230, 8'd239, 8'd247, 8'd255
    };

    localparam logic [7:0] EXPAND6 [64] = '{
        8'd0,   8'd4,   8'd8,   8'd12,  8'd16,  8'd20,  8'd24,  8'd28,
        8'd32,  8'd36,  8'd40,  8'd45,  8'd49,  8'd53,  8'd57,  8'd61,
        8'd65,  8'd69,  8'd73,  8'd77,  8'd81,  8'd85,  8'd89,  8'd93,
        8'd97,  8'd101, 8'd105, 8'd109, 8'd113, 8'd117, 8'd121, 8'd125,
        8'd130, 8'd134, 8'd138, 8'd142, 8'd146, 8'd150, 8'd154, 8'd158,
        8'd162, 8'd166, 8'd170, 8'd174, 8'd178, 8'd182, 8'd186, 8'd190,
        8'd194, 8'd198, 8'd202, 8'd206, 8'd210, 8'd215, 8'd219, 8'd223,
        8'd227, 8'd231, 8'd235, 8'd239, 8'd243, 8'd247, 8'd251, 8'd255
    };

endpackage

`default_nettype wire

/* rtl/pxu_pack.sv */
// ============================================================================
// pxu_pack - byte to pixel packer
// Holds the frame position, row counter, byte budget and partial pixel, and
// turns each accepted stream byte into one result in a single pass.
// ============================================================================
`default_nettype none

module pxu_pack
    import pxu_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_first,
    input  wire t_cfg       i_cfg,
    output t_result         o_result
);

    logic [ADDR_BITS-1:0]   r_addr,  n_addr;
    logic [WIDTH_BITS-1:0]  r_row,   n_row;
    logic [1:0]             r_cnt,   n_cnt;
    logic [23:0]            r_part,  n_part;
    logic [BUDGET_BITS-1:0] r_left,  n_left;

    logic [WIDTH_BITS-1:0]  eff_width;
    logic [ADDR_BITS-1:0]   e_addr;
    logic [WIDTH_BITS-1:0]  e_row;
    logic [1:0]             e_cnt;
    logic [23:0]            e_part;
    logic [BUDGET_BITS-1:0] e_left;
    logic [BUDGET_BITS-1:0] left_dec;
    logic [2:0]             need;
    logic [2:0]             held_plus;
    logic                   complete;
    logic [7:0]             b0, b1, b2;
    logic [15:0]            px565;
    logic [31:0]            value;

    // Saturate the row width
    assign eff_width = (i_cfg.row_width > WIDTH_BITS'(MAX_WIDTH)) ?
                       WIDTH_BITS'(MAX_WIDTH) : i_cfg.row_width;

    // First byte of a frame reloads the position before the byte is used
    assign e_addr = i_first ? i_cfg.start_offset : r_addr;
    assign e_row  = i_first ? eff_width          : r_row;
    assign e_cnt  = i_first ? 2'd0               : r_cnt;
    assign e_part = i_first ? 24'd0              : r_part;
    assign e_left = i_first ? i_cfg.frame_bytes  : r_left;

    assign left_dec = e_left - BUDGET_BITS'(1);

    // Bytes per pixel
    always_comb begin
        case (i_cfg.format)
            FMT_RGBA:   need = 3'd4;
            FMT_RGB565: need = 3'd2;
            default:    need = 3'd3;
        endcase
    end

    assign held_plus = {1'b0, e_cnt} + 3'd1;
    assign complete  = (held_plus >= need);

    assign b0    = e_part[7:0];
    assign b1    = e_part[15:8];
    assign b2    = e_part[23:16];
    assign px565 = {i_data_byte, b0};

    // Pixel assembly
    always_comb begin
        case (i_cfg.format)
            FMT_RGBA:   value = {i_data_byte, b0, b1, b2};
            FMT_RGB565: value = {ALPHA_OPAQUE, EXPAND5[px565[15:11]],
                                 EXPAND6[px565[10:5]], EXPAND5[px565[4:0]]};
            default:    value = {ALPHA_OPAQUE, b0, b1, i_data_byte};
        endcase
    end

    // Result and next state
    always_comb begin
        n_addr = e_addr;
        n_row  = e_row;
        n_cnt  = e_cnt;
        n_part = e_part;
        n_left = e_left;

        o_result = '0;

        if (e_left == '0) begin
            o_result.overrun = 1'b1;
        end else begin
            n_left              = left_dec;
            o_result.frame_done = (left_dec == '0);
            if (complete) begin
                o_result.pixel_valid   = 1'b1;
                o_result.pixel_address = e_addr;
                o_result.pixel_value   = value;
                o_result.xor_merge     = (i_cfg.format == FMT_RGBXOR);
                // Row end jumps by pitch minus width
                if (e_row <= WIDTH_BITS'(1)) begin
                    n_addr = e_addr + ADDR_BITS'(i_cfg.row_pitch)
                             - ADDR_BITS'(eff_width) + ADDR_BITS'(1);
                    n_row  = eff_width;
                end else begin
                    n_addr = e_addr + ADDR_BITS'(1);
                    n_row  = e_row - WIDTH_BITS'(1);
                end
                n_cnt  = 2'd0;
                n_part = 24'd0;
            end else begin
                case (e_cnt)
                    2'd0:    n_part[7:0]   = i_data_byte;
                    2'd1:    n_part[15:8]  = i_data_byte;
                    default: n_part[23:16] = i_data_byte;
                endcase
                n_cnt = e_cnt + 2'd1;
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
            r_row  <= '0;
            r_cnt  <= '0;
            r_part <= '0;
            r_left <= '0;
        end else if (i_accept) begin
            r_addr <= n_addr;
            r_row  <= n_row;
            r_cnt  <= n_cnt;
            r_part <= n_part;
            r_left <= n_left;
        end
    end

endmodule

`default_nettype wire

/* rtl/pxu_skid.sv */
// ============================================================================
// pxu_skid - result output buffer
// Output register plus one skid entry, so the input side keeps taking bytes
// while a result waits and its ready does not depend on the output ready.
// ============================================================================
`default_nettype none

module pxu_skid
    import pxu_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    input  wire t_result i_data,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_data
);

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    take;
    logic    push;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign take    = r_out_valid && i_ready;
    assign push    = i_valid && !r_skid_valid;

    // Fill and drain
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (take) begin
            n_out_valid = r_skid_valid;
            n_out       = r_skid;
            n_skid_valid = 1'b0;
        end
        if (push) begin
            if (!r_out_valid || take) begin
                n_out_valid = 1'b1;
                n_out       = i_data;
            end else begin
                n_skid_valid = 1'b1;
                n_skid       = i_data;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

endmodule

`default_nettype wire

/* rtl/pixel_unpack_to_framebuffer_top.sv */
// Each result is registered in the output register, or the skid entry on a stall.
// Throughput: one byte per cycle while the skid is empty; one packer pass per result.
// Output stalls are absorbed by an output register and one skid entry.
// Reset (synchronous, active low) clears position, budget, partial pixel and
// buffers; registers return to format rgba, width 1, pitch 1, offset 0, budget 0.
// ============================================================================
// pixel_unpack_to_framebuffer_top - stream byte to framebuffer pixel writer
// Packs stream bytes into 32-bit pixels in four formats and emits one result
// per byte with the running framebuffer address and frame budget flags.
// ============================================================================
`default_nettype none

module pixel_unpack_to_framebuffer_top
    import pxu_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // Configuration write channel
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    // Byte stream in
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire logic [7:0]                s_axis_tdata,  // [7:0] data_byte
    input  wire logic                      s_axis_tuser,  // [0] first
    // Pixel writes out
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    output logic [55:0]                    m_axis_tdata,  // [23:0] pixel_address,
                                                          // [55:24] pixel_value
    output logic [2:0]                     m_axis_tuser,  // [0] pixel_valid,
                                                          // [1] xor_merge, [2] overrun
    output logic                           m_axis_tlast   // frame_done
);

    t_cfg    r_cfg;
    t_result pack_result;
    t_result out_result;
    logic    in_accept;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.format       <= FMT_RGBA;
            r_cfg.row_width    <= WIDTH_BITS'(1);
            r_cfg.row_pitch    <= PITCH_BITS'(1);
            r_cfg.start_offset <= '0;
            r_cfg.frame_bytes  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FORMAT:       r_cfg.format       <= t_format'(i_cfg_data[1:0]);
                REG_ROW_WIDTH:    r_cfg.row_width    <= i_cfg_data[WIDTH_BITS-1:0];
                REG_ROW_PITCH:    r_cfg.row_pitch    <= i_cfg_data[PITCH_BITS-1:0];
                REG_START_OFFSET: r_cfg.start_offset <= i_cfg_data[ADDR_BITS-1:0];
                REG_FRAME_BYTES:  r_cfg.frame_bytes  <= i_cfg_data[BUDGET_BITS-1:0];
                default:          ;
            endcase
        end
    end

    assign in_accept = s_axis_tvalid && s_axis_tready;

    // Packer
    pxu_pack u_pack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_data_byte (s_axis_tdata),
        .i_first     (s_axis_tuser),
        .i_cfg       (r_cfg),
        .o_result    (pack_result)
    );

    // Output buffering
    pxu_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (pack_result),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (out_result)
    );

    assign m_axis_tdata = {out_result.pixel_value, out_result.pixel_address};
    assign m_axis_tuser = {out_result.overrun, out_result.xor_merge,
                           out_result.pixel_valid};
    assign m_axis_tlast = out_result.frame_done;

endmodule

`default_nettype wire

/* rtl/pxu_checker.sv */
// ============================================================================
// pxu_checker - port-level checks for the pixel unpacker
// Watches the top level's ports and flags inconsistent results or stalls.
// ============================================================================
`default_nettype none

module pxu_checker
    import pxu_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    input  wire logic [55:0]               m_axis_tdata,
    input  wire logic [2:0]                m_axis_tuser,
    input  wire logic                      m_axis_tlast
);

    // No result straight out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A dropped byte never completes a pixel or a frame
    a_overrun_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2] |-> !m_axis_tuser[0] && !m_axis_tlast)
        else $error("overrun with pixel or frame done");

    // Without a pixel the address, value and merge flag are zero
    a_no_pixel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0 && !m_axis_tuser[1])
        else $error("payload without pixel");

    // Delta pixels are opaque
    a_xor_opaque: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[55:48] == ALPHA_OPAQUE)
        else $error("xor pixel not opaque");

    // Stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled result changed");

endmodule

bind pixel_unpack_to_framebuffer_top pxu_checker u_pxu_checker (.*);

`default_nettype wire

/* verif/pixel_unpack_to_framebuffer_top_tb.sv */
// ============================================================================
// pixel_unpack_to_framebuffer_top_tb - self-checking bench for the unpacker
// Drives stream bytes and register writes into the block and works out each
// framebuffer write with an independent model of the packing, addressing and
// byte budget. A short table of directed steps comes first, covering overrun,
// address wrap, format changes within a pixel and zero row width. Random
// frames follow in all four formats. Both stream sides idle and stall at random.
// ============================================================================

module pixel_unpack_to_framebuffer_top_tb;

    import pxu_pkg::*;

    localparam int WIDTH_CAP     = 4096;
    localparam int TARGET_BYTES  = 650;
    localparam int DRAIN_LIMIT   = 10000;

    // One directed step: a register write or a stream byte
    typedef struct {
        logic        is_cfg;
        t_cfg_reg    idx;
        logic [26:0] val;
        logic [7:0]  data;
        logic        first;
        logic        typed;
        t_result     want;
    } t_step;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    t_cfg_reg    cfg_index = REG_FORMAT;
    logic [26:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    // Writes the block still owes, oldest first
    t_result fb_writes_due [$];
    int      errors = 0;
    int      bytes_taken = 0;
    logic    steady = 1'b0;
    int      stall_left = 0;

    // Register copies
    t_format     fmt_reg;
    logic [12:0] width_reg;
    logic [14:0] pitch_reg;
    logic [23:0] offset_reg;
    logic [26:0] budget_reg;

    // Unpacker state copies
    logic [23:0] pos_addr;
    logic [12:0] row_pixels_left;
    logic [1:0]  held_count;
    logic [23:0] held_bytes;
    logic [26:0] budget_left;

    pixel_unpack_to_framebuffer_top dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .m_axis_tlast  (m_tlast)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------------
    function automatic int pixel_bytes(t_format f);
        return (f == FMT_RGBA) ? 4 : (f == FMT_RGB565) ? 2 : 3;
    endfunction

    function automatic logic [12:0] row_span();
        return (width_reg > WIDTH_CAP) ? 13'(WIDTH_CAP) : width_reg;
    endfunction

    // Channel expansion by rounding to nearest
    function automatic logic [7:0] widen(int v, int top);
        return 8'((v * 255 + top / 2) / top);
    endfunction

    task automatic unpack_byte(input logic [7:0] b, input logic f, output t_result r);
        int          need;
        logic [15:0] px;
        begin
            if (f) begin
                pos_addr        = offset_reg;
                row_pixels_left = row_span();
                held_count      = '0;
                held_bytes      = '0;
                budget_left     = budget_reg;
            end
            r = '0;
            if (budget_left == 0) begin
                r.overrun = 1'b1;
            end else begin
                need          = pixel_bytes(fmt_reg);
                budget_left   = budget_left - 1'b1;
                r.frame_done  = (budget_left == 0);
                if (int'(held_count) + 1 >= need) begin
                    // held bytes go in arrival order; the new byte completes the pixel
                    case (need)
                        4: r.pixel_value = {b, held_bytes[7:0], held_bytes[15:8],
                                            held_bytes[23:16]};
                        3: begin
                            r.pixel_value = {8'hff, held_bytes[7:0], held_bytes[15:8], b};
                            r.xor_merge   = (fmt_reg == FMT_RGBXOR);
                        end
                        default: begin
                            px = {b, held_bytes[7:0]};
                            r.pixel_value = {8'hff, widen(int'(px[15:11]), 31),
                                             widen(int'(px[10:5]), 63),
                                             widen(int'(px[4:0]), 31)};
                        end
                    endcase
                    r.pixel_valid   = 1'b1;
                    r.pixel_address = pos_addr;
                    pos_addr = pos_addr + 24'd1;
                    // end of row: skip the gap between width and pitch
                    if (row_pixels_left <= 1) begin
                        pos_addr        = pos_addr - 24'(row_span()) + 24'(pitch_reg);
                        row_pixels_left = row_span();
                    end else begin
                        row_pixels_left = row_pixels_left - 1'b1;
                    end
                    held_count = '0;
                    held_bytes = '0;
                end else begin
                    held_bytes[8*held_count +: 8] = b;
                    held_count = held_count + 1'b1;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // Register write, only once every owed write has come out
    task automatic write_reg(input t_cfg_reg idx, input logic [26:0] v);
        begin
            while (fb_writes_due.size() != 0)
                @(negedge clk);
            cfg_valid = 1'b1;
            cfg_index = idx;
            cfg_data  = v;
            do @(posedge clk); while (!cfg_ready);
            case (idx)
                REG_FORMAT:       fmt_reg    = t_format'(v[1:0]);
                REG_ROW_WIDTH:    width_reg  = v[12:0];
                REG_ROW_PITCH:    pitch_reg  = v[14:0];
                REG_START_OFFSET: offset_reg = v[23:0];
                REG_FRAME_BYTES:  budget_reg = v;
                default: ;
            endcase
            @(negedge clk);
            cfg_valid = 1'b0;
        end
    endtask

    // One stream byte; typed rows supply their own expected write
    task automatic push_byte(input logic [7:0] b, input logic f, input logic typed,
                             input t_result want);
        t_result predicted;
        int      gap;
        begin
            gap = pick_gap();
            if (gap > 0) begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            unpack_byte(b, f, predicted);
            fb_writes_due.push_back(typed ? want : predicted);
            if (!predicted.overrun)
                bytes_taken++;
            s_tvalid = 1'b1;
            s_tdata  = b;
            s_tuser  = f;
            do @(posedge clk); while (!s_tready);
            @(negedge clk);
            s_tvalid = 1'b0;
        end
    endtask

    // Output back-pressure: mostly ready, short and occasional long stalls
    always @(negedge clk) begin
        if (stall_left > 0) begin
            m_tready = 1'b0;
            stall_left--;
        end else if (steady || $urandom_range(0, 3) != 0) begin
            m_tready = 1'b1;
        end else begin
            m_tready = 1'b0;
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                                                     : $urandom_range(0, 2);
        end
    end

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        begin
            $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
            errors++;
        end
    endtask

    always @(posedge clk) begin
        t_result got;
        t_result want;
        if (rst_n && m_tvalid && m_tready) begin
            got.pixel_valid   = m_tuser[0];
            got.xor_merge     = m_tuser[1];
            got.overrun       = m_tuser[2];
            got.pixel_address = m_tdata[23:0];
            got.pixel_value   = m_tdata[55:24];
            got.frame_done    = m_tlast;
            if (fb_writes_due.size() == 0) begin
                report_mismatch("unexpected transaction", m_tdata[55:24], '0);
            end else begin
                want = fb_writes_due.pop_front();
                if (got.pixel_valid != want.pixel_valid)
                    report_mismatch("pixel_valid", got.pixel_valid, want.pixel_valid);
                if (got.pixel_address != want.pixel_address)
                    report_mismatch("pixel_address", got.pixel_address, want.pixel_address);
                if (got.pixel_value != want.pixel_value)
                    report_mismatch("pixel_value", got.pixel_value, want.pixel_value);
                if (got.xor_merge != want.xor_merge)
                    report_mismatch("xor_merge", got.xor_merge, want.xor_merge);
                if (got.frame_done != want.frame_done)
                    report_mismatch("frame_done", got.frame_done, want.frame_done);
                if (got.overrun != want.overrun)
                    report_mismatch("overrun", got.overrun, want.overrun);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Directed table helpers
    // ------------------------------------------------------------------------
    function automatic t_step cfg_row(t_cfg_reg idx, logic [26:0] v);
        t_step s;
        s = '{1'b1, idx, v, 8'h00, 1'b0, 1'b0, '0};
        return s;
    endfunction

    function automatic t_step byte_row(logic [7:0] d, logic f);
        t_step s;
        s = '{1'b0, REG_FORMAT, '0, d, f, 1'b0, '0};
        return s;
    endfunction

    function automatic t_step typed_row(logic [7:0] d, logic f, t_result w);
        t_step s;
        s = '{1'b0, REG_FORMAT, '0, d, f, 1'b1, w};
        return s;
    endfunction

    function automatic t_result res(logic v, logic [23:0] a, logic [31:0] px,
                                    logic done, logic ov);
        t_result r;
        r = '0;
        r.pixel_valid   = v;
        r.pixel_address = a;
        r.pixel_value   = px;
        r.frame_done    = done;
        r.overrun       = ov;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_step       directed [$];
        t_result     none;
        t_format     fmt_v;
        logic [12:0] width_v;
        logic [14:0] pitch_v;
        logic [23:0] offset_v;
        int          budget_v;
        int          need;
        int          nbytes;
        int          switch_at;
        int          drain;
        logic        f;

        none = '0;
        fmt_reg = FMT_RGBA;  width_reg = 13'd1;   pitch_reg = 15'd1;
        offset_reg = '0;     budget_reg = '0;
        pos_addr = '0;       row_pixels_left = '0; held_count = '0;
        held_bytes = '0;     budget_left = '0;

        directed = '{
            // nothing budgeted after reset
            typed_row(8'ha5, 1'b0, res(0, 0, 0, 0, 1)),
            // rgba, two-pixel rows, start two below the address wrap
            cfg_row(REG_FORMAT, FMT_RGBA),
            cfg_row(REG_ROW_WIDTH, 27'd2),
            cfg_row(REG_ROW_PITCH, 27'd5),
            cfg_row(REG_START_OFFSET, 27'hfffffe),
            cfg_row(REG_FRAME_BYTES, 27'd14),
            typed_row(8'h00, 1'b1, none),
            typed_row(8'h11, 1'b0, none),
            typed_row(8'h22, 1'b0, none),
            typed_row(8'hff, 1'b0, res(1, 24'hfffffe, 32'hff001122, 0, 0)),
            typed_row(8'h80, 1'b0, none),
            typed_row(8'h40, 1'b0, none),
            typed_row(8'h20, 1'b0, none),
            typed_row(8'h01, 1'b0, res(1, 24'hffffff, 32'h01804020, 0, 0)),
            // three bytes held, then the format drops to two-byte pixels
            byte_row(8'h77, 1'b0),
            byte_row(8'h88, 1'b0),
            byte_row(8'h99, 1'b0),
            cfg_row(REG_FORMAT, FMT_RGB565),
            byte_row(8'h12, 1'b0),
            // delta format; budget runs out with a pixel still incomplete
            cfg_row(REG_FORMAT, FMT_RGBXOR),
            byte_row(8'hab, 1'b0),
            typed_row(8'hcd, 1'b0, res(0, 0, 0, 1, 0)),
            typed_row(8'h3c, 1'b0, res(0, 0, 0, 0, 1)),
            // zero budget, then zero row width with a fresh frame
            cfg_row(REG_FORMAT, FMT_RGB),
            cfg_row(REG_ROW_WIDTH, 27'd0),
            cfg_row(REG_ROW_PITCH, 27'd3),
            cfg_row(REG_START_OFFSET, 27'd100),
            cfg_row(REG_FRAME_BYTES, 27'd0),
            typed_row(8'h5a, 1'b1, res(0, 0, 0, 0, 1)),
            cfg_row(REG_FRAME_BYTES, 27'd6),
            byte_row(8'h00, 1'b1),
            byte_row(8'hff, 1'b0),
            byte_row(8'hff, 1'b0),
            byte_row(8'hff, 1'b0),
            byte_row(8'h00, 1'b0),
            byte_row(8'hff, 1'b0)
        };

        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[i]) begin
            if (directed[i].is_cfg)
                write_reg(directed[i].idx, directed[i].val);
            else
                push_byte(directed[i].data, directed[i].first, directed[i].typed,
                          directed[i].want);
        end

        // Random frames until enough bytes have been taken in
        while (bytes_taken < TARGET_BYTES) begin
            steady = ($urandom_range(0, 5) == 0);
            fmt_v  = t_format'($urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0:       width_v = 13'd0;
                1:       width_v = 13'(WIDTH_CAP);
                2:       width_v = ($urandom_range(0, 1) != 0) ? 13'h1fff
                                                             : 13'($urandom_range(4097, 8190));
                default: width_v = 13'($urandom_range(1, 6));
            endcase
            case ($urandom_range(0, 9))
                0:       pitch_v = 15'd0;
                1:       pitch_v = 15'h7fff;
                default: pitch_v = 15'($urandom_range(1, 10));
            endcase
            offset_v = ($urandom_range(0, 3) == 0) ? 24'($urandom_range(16777200, 16777215))
                                                   : 24'($urandom);
            need     = pixel_bytes(fmt_v);
            budget_v = $urandom_range(1, 12) * need;
            case ($urandom_range(0, 9))
                0:       budget_v = budget_v + $urandom_range(1, need - 1);
                1:       budget_v = 0;
                2:       budget_v = 27'h7ffffff;
                default: ;
            endcase
            if (budget_v == 27'h7ffffff)
                nbytes = $urandom_range(10, 40);
            else if (budget_v == 0)
                nbytes = $urandom_range(1, 3);
            else
                nbytes = budget_v + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
            switch_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, nbytes) : -1;

            write_reg(REG_FORMAT, 27'(fmt_v));
            write_reg(REG_ROW_WIDTH, 27'(width_v));
            write_reg(REG_ROW_PITCH, 27'(pitch_v));
            write_reg(REG_START_OFFSET, 27'(offset_v));
            write_reg(REG_FRAME_BYTES, 27'(budget_v));

            for (int k = 0; k < nbytes; k++) begin
                if (k == switch_at)
                    write_reg(REG_FORMAT, 27'($urandom_range(0, 3)));
                // mostly a clean frame start; now and then a stray or missing first
                f = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0);
                push_byte(8'($urandom_range(0, 255)), f, 1'b0, none);
            end
        end

        steady = 1'b0;
        drain  = 0;
        while (fb_writes_due.size() != 0 && drain < DRAIN_LIMIT) begin
            @(negedge clk);
            drain++;
        end
        if (fb_writes_due.size() != 0) begin
            $display("%0d expected writes never came out", fb_writes_due.size());
            errors++;
        end
        repeat (8) @(negedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Hang guard
    initial begin
        #(12 * 500000);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* pixel_unpack_to_framebuffer_top.f */
rtl/pxu_pkg.sv
rtl/pxu_pack.sv
rtl/pxu_skid.sv
rtl/pixel_unpack_to_framebuffer_top.sv
rtl/pxu_checker.sv
verif/pixel_unpack_to_framebuffer_top_tb.sv
